// ===== rtl/core/bounded_ordered_list_store_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded ordered list store
// Shorthand for clocked concurrent checks that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_STORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_STORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define BOLS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("bols invariant violated");

// consequent holds in the same cycle as the antecedent
`define BOLS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bols implication violated");

// consequent holds in the cycle after the antecedent
`define BOLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bols next-cycle check violated");

`endif

// ===== rtl/core/bols_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bols_pkg
// Field widths, operation and status codes, and cell control types.
// ----------------------------------------------------------------------------
package bols_pkg;

   localparam int FUNC_W    = 4;
   localparam int DATA_W    = 32;
   localparam int POS_IN_W  = 5;
   localparam int POS_OUT_W = 4;
   localparam int COUNT_W   = 5;
   localparam int STATUS_W  = 2;

   localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd1;
   localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd2;
   localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd4;
   localparam logic [FUNC_W-1:0] FN_READ       = 4'd5;
   localparam logic [FUNC_W-1:0] FN_FIND       = 4'd6;
   localparam logic [FUNC_W-1:0] FN_MAX        = 4'd7;
   localparam logic [FUNC_W-1:0] FN_MIN        = 4'd8;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_INSERT     = 2'd1,
      CELL_SHIFT_DOWN = 2'd2,
      CELL_ROTATE     = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type           mode;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/bols_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bols_req_if
// Request channel: one list operation per handshake.
// ----------------------------------------------------------------------------
interface bols_req_if import bols_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;
   logic [POS_IN_W-1:0]      position_in;

   modport source (output valid, func, value, position_in, input ready);
   modport sink   (input valid, func, value, position_in, output ready);
endinterface

// ===== rtl/core/bols_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bols_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface bols_rsp_if import bols_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data;
   logic                     found;
   logic [POS_OUT_W-1:0]     position_out;
   logic [COUNT_W-1:0]       count;
   logic                     is_empty;

   modport source (output valid, status, data, found, position_out, count, is_empty,
                   input ready);
   modport sink   (input valid, status, data, found, position_out, count, is_empty,
                   output ready);
endinterface

// ===== rtl/core/bounded_ordered_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_store
// Ordered list of up to CAPACITY signed words kept in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries func, value and position_in; rsp_bus returns status, data,
//   found, position_out, count and is_empty, one response per request.
//   Push, insert, pop and every failed or empty-store request finish in the
//   accept cycle: the response is valid on the next cycle.
//   Read, find, max and min rotate the live entries once through the chain,
//   one entry per cycle past a single compare unit at the head cell, and the
//   list is back in its original order when they finish.
//   One request is in flight at a time: with rsp_bus.ready high, short
//   requests are taken every cycle and a scan holds the input off from its
//   accept until its response is valid.
//   req_bus.ready is high when no scan is running and the response register
//   is empty or being taken this cycle.
//   A stalled response (rsp_bus.ready low) holds its payload and blocks new
//   requests until taken.
//   Reset empties the list (count zero) and drops any pending response;
//   slot contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
`include "bounded_ordered_list_store_assert.svh"

module bounded_ordered_list_store import bols_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   bols_req_if.sink   req_bus,
   bols_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CW    = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [FUNC_W-1:0]        op_ff, op_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         where_ff, where_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [POS_OUT_W-1:0]     rsp_where_ff, rsp_where_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   logic                     req_fire;
   logic [CW-1:0]            count_x, pos_x, at_pos;
   logic                     is_full, is_empty_now, last_step;
   logic                     start_scan, load_rsp;
   logic                     push_grow, scan_done;
   logic signed [DATA_W-1:0] head;
   cell_ctrl_type            cell_ctrl;
   logic [CW-1:0]            cell_mark;
   logic signed [DATA_W-1:0] cell_q [CAPACITY];

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d;
      if (gi == 0) begin : g_first
         assign left_d = cell_ctrl.value;
      end else begin : g_mid_l
         assign left_d = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
         assign right_d = cell_q[gi];
      end else begin : g_mid_r
         assign right_d = cell_q[gi+1];
      end
      bols_cell #(
         .IDX    (gi),
         .MARK_W (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .mark       (cell_mark),
         .from_left  (left_d),
         .from_right (right_d),
         .wrap       (cell_q[0]),
         .entry      (cell_q[gi])
      );
   end

   assign head = cell_q[0];

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign count_x      = CW'(count_ff);
   assign pos_x        = CW'(req_bus.position_in);
   assign is_full      = (count_ff == CNT_W'(CAPACITY));
   assign is_empty_now = (count_ff == '0);
   assign last_step    = (CNT_W'(step_ff) == (count_ff - 1'b1));

   always_comb begin
      at_pos = pos_x;
      if (req_bus.func == FN_PUSH_BACK) begin
         at_pos = count_x;
      end else if (req_bus.func == FN_PUSH_FRONT) begin
         at_pos = '0;
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      pos_in          = pos_ff;
      step_in         = step_ff;
      acc_in          = acc_ff;
      found_in        = found_ff;
      where_in        = where_ff;
      start_scan      = 1'b0;
      load_rsp        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_where_in    = rsp_where_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_empty_in    = rsp_empty_ff;
      cell_ctrl.mode  = CELL_HOLD;
      cell_ctrl.value = req_bus.value;
      cell_mark       = '0;

      if (req_fire) begin
         rsp_status_in = STS_OK;
         rsp_data_in   = '0;
         rsp_found_in  = 1'b0;
         rsp_where_in  = '0;
         case (req_bus.func)
            FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT: begin
               if (at_pos > count_x) begin
                  rsp_status_in = STS_BAD_INDEX;
               end else if (is_full) begin
                  rsp_status_in = STS_FULL;
               end else begin
                  cell_ctrl.mode = CELL_INSERT;
                  cell_mark      = at_pos;
                  count_in       = count_ff + 1'b1;
               end
            end
            FN_POP_BACK: begin
               if (is_empty_now) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            FN_POP_FRONT: begin
               if (is_empty_now) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  cell_ctrl.mode = CELL_SHIFT_DOWN;
                  count_in       = count_ff - 1'b1;
               end
            end
            FN_READ: begin
               if (pos_x >= count_x) begin
                  rsp_status_in = STS_BAD_INDEX;
               end else begin
                  start_scan = 1'b1;
               end
            end
            FN_FIND, FN_MAX, FN_MIN: begin
               if (is_empty_now) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  start_scan = 1'b1;
               end
            end
            default: begin
               rsp_status_in = STS_OK;
            end
         endcase
         rsp_count_in = COUNT_W'(count_in);
         rsp_empty_in = (count_in == '0);
         if (start_scan) begin
            state_in = S_SCAN;
            op_in    = req_bus.func;
            key_in   = req_bus.value;
            pos_in   = pos_x;
            step_in  = '0;
            found_in = 1'b0;
            where_in = '0;
         end else begin
            load_rsp = 1'b1;
         end
      end else if (state_ff == S_SCAN) begin
         // head cell holds entry number step_ff; rotate the live entries by one
         cell_ctrl.mode = CELL_ROTATE;
         cell_mark      = count_x - 1'b1;
         case (op_ff)
            FN_READ: begin
               if (CW'(step_ff) == pos_ff) begin
                  acc_in = head;
               end
            end
            FN_FIND: begin
               if (!found_ff && (head == key_ff)) begin
                  found_in = 1'b1;
                  where_in = step_ff;
               end
            end
            FN_MAX: begin
               if ((step_ff == '0) || (head > acc_ff)) begin
                  acc_in = head;
               end
            end
            FN_MIN: begin
               if ((step_ff == '0) || (head < acc_ff)) begin
                  acc_in = head;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         step_in = step_ff + 1'b1;
         if (last_step) begin
            state_in      = S_IDLE;
            load_rsp      = 1'b1;
            rsp_status_in = STS_OK;
            rsp_data_in   = (op_ff == FN_FIND) ? '0 : acc_in;
            rsp_found_in  = found_in;
            rsp_where_in  = POS_OUT_W'(where_in);
            rsp_count_in  = COUNT_W'(count_ff);
            rsp_empty_in  = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      found_ff      <= found_in;
      where_ff      <= where_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_where_ff  <= rsp_where_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.data         = rsp_data_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.position_out = rsp_where_ff;
   assign rsp_bus.count        = rsp_count_ff;
   assign rsp_bus.is_empty     = rsp_empty_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   assign push_grow = req_fire && (req_bus.func == FN_PUSH_BACK) && !is_full;
   assign scan_done = (state_ff == S_SCAN) && last_step;

   `BOLS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `BOLS_ASSERT_IMPLY(a_scan_blocks_req, clock, reset, state_ff == S_SCAN, !req_bus.ready)
   `BOLS_ASSERT_IMPLY(a_scan_step_live, clock, reset, state_ff == S_SCAN, CNT_W'(step_ff) < count_ff)
   `BOLS_ASSERT_NEXT(a_push_grows, clock, reset, push_grow, count_ff == $past(count_ff) + 1'b1)
   `BOLS_ASSERT_NEXT(a_scan_responds, clock, reset, scan_done, rsp_valid_ff && state_ff == S_IDLE)

endmodule

// ===== rtl/core/bols_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bols_cell
// One list slot: holds, loads, or takes a neighbor's entry per broadcast mode.
// ----------------------------------------------------------------------------
module bols_cell import bols_pkg::*; #(
   parameter int IDX    = 0,
   parameter int MARK_W = 5
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [MARK_W-1:0]        mark,
   input  logic signed [DATA_W-1:0] from_left,
   input  logic signed [DATA_W-1:0] from_right,
   input  logic signed [DATA_W-1:0] wrap,
   output logic signed [DATA_W-1:0] entry
);

   localparam logic [MARK_W-1:0] MY_IDX = MARK_W'(IDX);

   logic signed [DATA_W-1:0] entry_ff, entry_in;

   // insert: mark is the gap position; rotate: mark is the last live slot
   always_comb begin
      entry_in = entry_ff;
      case (ctrl.mode)
         CELL_INSERT: begin
            if (MY_IDX == mark) begin
               entry_in = ctrl.value;
            end else if (MY_IDX > mark) begin
               entry_in = from_left;
            end
         end
         CELL_SHIFT_DOWN: begin
            entry_in = from_right;
         end
         CELL_ROTATE: begin
            if (MY_IDX == mark) begin
               entry_in = wrap;
            end else if (MY_IDX < mark) begin
               entry_in = from_right;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bounded_ordered_list_store. A directed table covers
// empty, full and bad-index cases and the value extremes. A long random run
// follows that drifts the list between empty and full. Every response is
// compared field by field against its table entry or an in-bench list predictor.
// ----------------------------------------------------------------------------
module tb;
   import bols_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 1730;
   localparam int IDLE_PCT     = 18;
   localparam int HOLD_AT      = 400;   // responses taken before the long stall
   localparam int HOLD_CYCLES  = 150;
   localparam int STALL_LIMIT  = 1000;
   localparam int CALM_FIRST   = 700;   // first of the random items sent with no gaps
   localparam int CALM_LAST    = 1000;

   localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
   localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_NEG = -32'sd1;
   localparam logic signed [DATA_W-1:0] VAL_ALT = 32'sh5555_5555;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic [POS_IN_W-1:0]      position;
   } list_req_t;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data;
      logic                     found;
      logic [POS_OUT_W-1:0]     position;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } list_rsp_t;

   typedef struct {
      list_req_t r;
      bit        typed;
      list_rsp_t rsp;
      int        reps;   // repeated rows take a fresh random value each time
   } dir_row_t;

   logic clock;
   logic reset;

   bols_req_if req_bus();
   bols_rsp_if rsp_bus();

   bounded_ordered_list_store #(.CAPACITY(CAPACITY)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted list contents, front at index 0
   logic signed [DATA_W-1:0] stored_vals[CAPACITY];
   int                       stored_len = 0;

   list_rsp_t owed_results[$];
   dir_row_t  dir_rows[$];
   int        mismatches = 0;
   int        rsp_taken  = 0;
   int        quiet_cycles = 0;
   bit        no_gaps = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic list_rsp_t predict_list_op(list_req_t r);
      list_rsp_t                e;
      int                       at;
      logic signed [DATA_W-1:0] best;
      e = '0;
      case (r.func)
         FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT: begin
            if (r.func == FN_PUSH_BACK) at = stored_len;
            else if (r.func == FN_PUSH_FRONT) at = 0;
            else at = int'(r.position);
            // index check wins over the full check
            if (at > stored_len) begin
               e.status = STS_BAD_INDEX;
            end else if (stored_len >= CAPACITY) begin
               e.status = STS_FULL;
            end else begin
               for (int i = stored_len; i > at; i--) stored_vals[i] = stored_vals[i-1];
               stored_vals[at] = r.value;
               stored_len++;
            end
         end
         FN_POP_BACK: begin
            if (stored_len == 0) e.status = STS_EMPTY;
            else stored_len--;
         end
         FN_POP_FRONT: begin
            if (stored_len == 0) begin
               e.status = STS_EMPTY;
            end else begin
               for (int i = 0; i + 1 < stored_len; i++) stored_vals[i] = stored_vals[i+1];
               stored_len--;
            end
         end
         FN_READ: begin
            if (int'(r.position) >= stored_len) e.status = STS_BAD_INDEX;
            else e.data = stored_vals[r.position];
         end
         FN_FIND: begin
            if (stored_len == 0) begin
               e.status = STS_EMPTY;
            end else begin
               for (int i = 0; i < stored_len; i++) begin
                  if (!e.found && stored_vals[i] == r.value) begin
                     e.found    = 1'b1;
                     e.position = POS_OUT_W'(i);
                  end
               end
            end
         end
         FN_MAX, FN_MIN: begin
            if (stored_len == 0) begin
               e.status = STS_EMPTY;
            end else begin
               best = stored_vals[0];
               for (int i = 1; i < stored_len; i++) begin
                  if ((r.func == FN_MAX) ? (stored_vals[i] > best) : (stored_vals[i] < best))
                     best = stored_vals[i];
               end
               e.data = best;
            end
         end
         default: ;
      endcase
      e.count    = COUNT_W'(stored_len);
      e.is_empty = (stored_len == 0);
      return e;
   endfunction

   // mix of wide random, small clustered values (duplicates), extremes, copies
   function automatic logic signed [DATA_W-1:0] pick_value(int hit_pct);
      int pick;
      pick = $urandom_range(99);
      if (stored_len > 0 && pick < hit_pct)
         return stored_vals[$urandom_range(stored_len - 1)];
      pick = $urandom_range(9);
      if (pick < 5) return $urandom();
      if (pick < 8) return DATA_W'($signed($urandom_range(16)) - 8);
      case ($urandom_range(3))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return VAL_NEG;
         default: return '0;
      endcase
   endfunction

   function automatic list_req_t random_list_req(bit filling);
      list_req_t r;
      int        pick;
      int        push_w;
      int        pop_w;
      pick   = $urandom_range(99);
      push_w = filling ? 45 : 12;
      pop_w  = filling ? 10 : 40;
      r.value    = pick_value(10);
      r.position = POS_IN_W'($urandom_range(31));
      if (pick < 4) begin
         r.func = FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
      end else if (pick < 4 + push_w) begin
         case ($urandom_range(2))
            0: r.func = FN_PUSH_BACK;
            1: r.func = FN_PUSH_FRONT;
            default: begin
               r.func = FN_INSERT;
               if ($urandom_range(99) < 85)
                  r.position = POS_IN_W'($urandom_range(stored_len + 1));
            end
         endcase
      end else if (pick < 4 + push_w + pop_w) begin
         r.func = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
      end else begin
         case ($urandom_range(3))
            0: begin
               r.func = FN_READ;
               if ($urandom_range(99) < 85) r.position = POS_IN_W'($urandom_range(stored_len));
            end
            1: begin
               r.func  = FN_FIND;
               r.value = pick_value(60);
            end
            2: r.func = FN_MAX;
            default: r.func = FN_MIN;
         endcase
      end
      return r;
   endfunction

   task automatic add_checked(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value,
                              int pos, logic [STATUS_W-1:0] status,
                              logic signed [DATA_W-1:0] data, bit found, int where,
                              int count);
      dir_row_t row;
      row.r       = '{func: func, value: value, position: POS_IN_W'(pos)};
      row.typed   = 1'b1;
      row.rsp     = '{status: status, data: data, found: found,
                      position: POS_OUT_W'(where), count: COUNT_W'(count),
                      is_empty: (count == 0)};
      row.reps    = 1;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic add_predicted(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value,
                                int pos, int reps);
      dir_row_t row;
      row.r     = '{func: func, value: value, position: POS_IN_W'(pos)};
      row.typed = 1'b0;
      row.rsp   = '0;
      row.reps  = reps;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // valid stays high across back-to-back requests; only an idle cycle lowers it
   task automatic send_request(list_req_t r, bit typed, list_rsp_t typed_rsp);
      list_rsp_t predicted;
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= r.func;
      req_bus.value       <= r.value;
      req_bus.position_in <= r.position;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_list_op(r);
      owed_results.insert(owed_results.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      list_rsp_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_taken++;
         if (owed_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = owed_results[0];
            owed_results.delete(0);
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_bus.status));
            check_field("data", want.data, rsp_bus.data);
            check_field("found", DATA_W'(want.found), DATA_W'(rsp_bus.found));
            check_field("position_out", DATA_W'(want.position), DATA_W'(rsp_bus.position_out));
            check_field("count", DATA_W'(want.count), DATA_W'(rsp_bus.count));
            check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp_bus.is_empty));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off that backs up the input
   initial begin
      bit held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && rsp_taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      bit        filling;
      list_req_t r;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FN_PUSH_BACK;
      req_bus.value       <= '0;
      req_bus.position_in <= '0;

      // empty store: every query and pop reports empty, reads and inserts bad index
      add_checked(FN_POP_BACK,  '0, 0, STS_EMPTY, '0, 0, 0, 0);
      add_checked(FN_POP_FRONT, '0, 0, STS_EMPTY, '0, 0, 0, 0);
      add_checked(FN_FIND,      32'sd5, 0, STS_EMPTY, '0, 0, 0, 0);
      add_checked(FN_MAX,       '0, 0, STS_EMPTY, '0, 0, 0, 0);
      add_checked(FN_MIN,       '0, 0, STS_EMPTY, '0, 0, 0, 0);
      add_checked(FN_READ,      '0, 0, STS_BAD_INDEX, '0, 0, 0, 0);
      add_checked(FN_INSERT,    32'sd7, 1, STS_BAD_INDEX, '0, 0, 0, 0);
      add_checked(FN_UNUSED_LO, VAL_NEG, 31, STS_OK, '0, 0, 0, 0);
      add_checked(FN_UNUSED_HI, VAL_MIN, 0, STS_OK, '0, 0, 0, 0);
      // build [0, MIN, ALT, MAX, -1]
      add_checked(FN_PUSH_BACK,  VAL_MAX, 0, STS_OK, '0, 0, 0, 1);
      add_checked(FN_PUSH_FRONT, VAL_MIN, 0, STS_OK, '0, 0, 0, 2);
      add_checked(FN_INSERT,     VAL_NEG, 2, STS_OK, '0, 0, 0, 3);
      add_checked(FN_INSERT,     '0, 0, STS_OK, '0, 0, 0, 4);
      add_checked(FN_INSERT,     VAL_ALT, 2, STS_OK, '0, 0, 0, 5);
      add_checked(FN_READ,       '0, 3, STS_OK, VAL_MAX, 0, 0, 5);
      add_checked(FN_READ,       '0, 5, STS_BAD_INDEX, '0, 0, 0, 5);
      add_checked(FN_READ,       '0, 31, STS_BAD_INDEX, '0, 0, 0, 5);
      add_checked(FN_MAX,        '0, 0, STS_OK, VAL_MAX, 0, 0, 5);
      add_checked(FN_MIN,        '0, 0, STS_OK, VAL_MIN, 0, 0, 5);
      add_checked(FN_FIND,       VAL_NEG, 0, STS_OK, '0, 1, 4, 5);
      add_checked(FN_FIND,       32'sd12345, 0, STS_OK, '0, 0, 0, 5);
      add_checked(FN_POP_FRONT,  '0, 0, STS_OK, '0, 0, 0, 4);
      add_checked(FN_POP_BACK,   '0, 0, STS_OK, '0, 0, 0, 3);
      // fill up, then hit the full store from every side
      add_predicted(FN_PUSH_BACK, '0, 0, 13);
      add_checked(FN_PUSH_FRONT, 32'sd1, 0, STS_FULL, '0, 0, 0, 16);
      add_checked(FN_INSERT,     32'sd1, 16, STS_FULL, '0, 0, 0, 16);
      add_checked(FN_INSERT,     32'sd1, 17, STS_BAD_INDEX, '0, 0, 0, 16);
      add_checked(FN_PUSH_BACK,  32'sd1, 0, STS_FULL, '0, 0, 0, 16);
      add_checked(FN_READ,       '0, 16, STS_BAD_INDEX, '0, 0, 0, 16);
      add_predicted(FN_READ, '0, 15, 1);
      add_predicted(FN_FIND, VAL_ALT, 0, 1);
      add_predicted(FN_MAX, '0, 0, 1);
      add_predicted(FN_POP_FRONT, '0, 0, 16);
      add_checked(FN_POP_BACK, '0, 0, STS_EMPTY, '0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++) begin
            r = dir_rows[i].r;
            if (dir_rows[i].reps > 1) r.value = $urandom();
            send_request(r, dir_rows[i].typed, dir_rows[i].rsp);
         end
      end

      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gaps = (n >= CALM_FIRST && n < CALM_LAST);
         if (stored_len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
         else if (stored_len == 0 && $urandom_range(3) == 0) filling = 1'b1;
         else if ($urandom_range(49) == 0) filling = !filling;
         send_request(random_list_req(filling), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
      no_gaps = 1'b0;

      while (owed_results.size() != 0) @(posedge clock);
      // wait out a full-length scan and catch any stray response after it
      repeat (2 * CAPACITY + 4) @(posedge clock);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bols_pkg.sv
rtl/core/bols_req_if.sv
rtl/core/bols_rsp_if.sv
rtl/core/bols_cell.sv
rtl/core/bounded_ordered_list_store.sv
sim/tb.sv
